FILE: sv/srtf_pkg.sv
// Shared types, sizes and codes of the shortest-remaining-time-first scheduler.
// Depends on nothing; every other file refers to it by scoped names.
package srtf_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int TIME_BITS     = 16;
  localparam int SLOT_BITS     = $clog2(MAX_PROCESSES);
  localparam int CNT_BITS      = $clog2(MAX_PROCESSES + 1);
  localparam int CODE_BITS     = 3;
  localparam int PID_BITS      = 5;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [CODE_BITS-1:0] code_t;

  // Request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result codes
  localparam code_t RES_RAN       = 3'd0;
  localparam code_t RES_COMPLETED = 3'd1;
  localparam code_t RES_IDLE      = 3'd2;
  localparam code_t RES_LOADED    = 3'd3;
  localparam code_t RES_FULL      = 3'd4;

  // Table write request: a load writes arrival, burst and remaining time, an
  // update rewrites the remaining time and, on first run, the first run tick.
  typedef struct packed {
    logic  load_we;
    logic  upd_we;
    logic  first_we;
    slot_t slot;
    time_t arrival;
    time_t burst;
    time_t remaining;
    time_t first_run;
  } tbl_wr_t;

  // Registered read of one slot
  typedef struct packed {
    time_t arrival;
    time_t burst;
    time_t remaining;
    time_t first_run;
    logic  started;
  } tbl_rd_t;

endpackage

FILE: sv/srtf_table.sv
// Process table of the scheduler: per-slot memories and started flags.
// One shared read address, registered read data. Uses srtf_pkg.
module srtf_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srtf_pkg::slot_t   rd_addr_i,
  input  srtf_pkg::tbl_wr_t wr_i,
  output srtf_pkg::tbl_rd_t rd_o
);

  srtf_pkg::time_t arrival_mem   [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t burst_mem     [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t remaining_mem [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t first_run_mem [srtf_pkg::MAX_PROCESSES];
  logic [srtf_pkg::MAX_PROCESSES-1:0] started_q;

  srtf_pkg::tbl_rd_t rd_q;

  // Write the slot memories and read the addressed slot
  always_ff @(posedge clk_i) begin
    if (wr_i.load_we) begin
      arrival_mem[wr_i.slot] <= wr_i.arrival;
      burst_mem[wr_i.slot]   <= wr_i.burst;
    end
    if (wr_i.load_we || wr_i.upd_we) begin
      remaining_mem[wr_i.slot] <= wr_i.remaining;
    end
    if (wr_i.first_we) begin
      first_run_mem[wr_i.slot] <= wr_i.first_run;
    end
    rd_q.arrival   <= arrival_mem[rd_addr_i];
    rd_q.burst     <= burst_mem[rd_addr_i];
    rd_q.remaining <= remaining_mem[rd_addr_i];
    rd_q.first_run <= first_run_mem[rd_addr_i];
    rd_q.started   <= started_q[rd_addr_i];
  end

  // Clear a flag on load, set it on first run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= '0;
    end else if (wr_i.load_we) begin
      started_q[wr_i.slot] <= 1'b0;
    end else if (wr_i.first_we) begin
      started_q[wr_i.slot] <= 1'b1;
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: sv/srtf_min_unit.sv
// Shared compare unit: when enabled, tests one slot a cycle for eligibility
// and keeps the least remaining time seen so far with its slot. Uses srtf_pkg.
module srtf_min_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            cmp_en_i,
  input  srtf_pkg::slot_t idx_i,
  input  srtf_pkg::time_t arrival_i,
  input  srtf_pkg::time_t remaining_i,
  input  srtf_pkg::time_t clock_i,
  output logic            found_o,
  output srtf_pkg::slot_t pick_o
);

  logic            found_q, found_d;
  srtf_pkg::time_t best_q, best_d;
  srtf_pkg::slot_t pick_q, pick_d;
  logic            eligible;
  logic            better;

  // Strict less-than keeps the lowest slot on ties, as slots come in order
  assign eligible = (arrival_i <= clock_i) && (remaining_i != '0);
  assign better   = !found_q || (remaining_i < best_q);

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    pick_d  = pick_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (cmp_en_i && eligible && better) begin
      found_d = 1'b1;
      best_d  = remaining_i;
      pick_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    pick_q <= pick_d;
  end

  assign found_o = found_q;
  assign pick_o  = pick_q;

endmodule

FILE: sv/shortest_remaining_time_scheduler_core.sv
// A load, or a tick with nothing loaded, answers in the cycle after it is taken;
// other ticks pass scan, drain and fetch, then update unless nothing is eligible.
// Loads can be taken one a cycle; a tick holds busy_o until its result, so no new
// request is taken meanwhile. The scan reads one table slot a cycle into the shared
// compare unit. Reset clears counts, clock and started flags at once; the receiver
// cannot stall. Top level: sequencer over srtf_table and srtf_min_unit. Uses srtf_pkg.
module shortest_remaining_time_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_length_i,
  output logic        result_valid_o,
  output logic [2:0]  result_code_o,
  output logic [4:0]  process_id_o,
  output logic [15:0] time_after_o,
  output logic [15:0] remaining_left_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic [15:0] response_o,
  output logic        all_done_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0]      state_q, state_d;
  srtf_pkg::slot_t idx_q, idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  srtf_pkg::slot_t cmp_idx_q;
  srtf_pkg::cnt_t  loaded_q, loaded_d;
  srtf_pkg::cnt_t  finished_q, finished_d;
  srtf_pkg::time_t clock_q, clock_d;

  logic                        valid_q, valid_d;
  srtf_pkg::code_t             code_q, code_d;
  logic [srtf_pkg::PID_BITS-1:0] pid_q, pid_d;
  srtf_pkg::time_t             rem_q, rem_d;
  srtf_pkg::time_t             tat_q, tat_d;
  srtf_pkg::time_t             wt_q, wt_d;
  srtf_pkg::time_t             rsp_q, rsp_d;

  srtf_pkg::slot_t   rd_addr;
  srtf_pkg::tbl_wr_t wr;
  srtf_pkg::tbl_rd_t rd;
  logic              clear_min;
  logic              found;
  srtf_pkg::slot_t   pick;

  srtf_pkg::time_t rem_new;
  srtf_pkg::time_t clock_inc;
  srtf_pkg::time_t first_run;
  srtf_pkg::time_t tat;
  logic            accept;
  logic            last_slot;

  srtf_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  srtf_min_unit u_min (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear_min),
    .cmp_en_i    (cmp_vld_q),
    .idx_i       (cmp_idx_q),
    .arrival_i   (rd.arrival),
    .remaining_i (rd.remaining),
    .clock_i     (clock_q),
    .found_o     (found),
    .pick_o      (pick)
  );

  assign accept    = start_i && (state_q == ST_IDLE);
  assign last_slot = (srtf_pkg::cnt_t'(idx_q) + srtf_pkg::cnt_t'(1)) == loaded_q;
  assign rem_new   = rd.remaining - srtf_pkg::time_t'(1);
  assign clock_inc = clock_q + srtf_pkg::time_t'(1);
  assign first_run = rd.started ? rd.first_run : clock_q;
  assign tat       = clock_inc - rd.arrival;

  // Sequence a request: load or empty tick at once, else scan, fetch, update any pick
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    loaded_d   = loaded_q;
    finished_d = finished_q;
    clock_d    = clock_q;
    valid_d    = 1'b0;
    code_d     = code_q;
    pid_d      = pid_q;
    rem_d      = rem_q;
    tat_d      = tat_q;
    wt_d       = wt_q;
    rsp_d      = rsp_q;
    rd_addr    = idx_q;
    clear_min  = 1'b0;
    wr         = '0;
    wr.slot    = srtf_pkg::slot_t'(loaded_q);
    wr.arrival = arrival_time_i;
    wr.burst   = burst_length_i;
    wr.remaining = burst_length_i;
    wr.first_run = clock_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          pid_d   = '0;
          rem_d   = '0;
          tat_d   = '0;
          wt_d    = '0;
          rsp_d   = '0;
          if (req_type_i == srtf_pkg::REQ_LOAD) begin
            if (loaded_q == srtf_pkg::cnt_t'(srtf_pkg::MAX_PROCESSES)) begin
              code_d = srtf_pkg::RES_FULL;
            end else begin
              wr.load_we = 1'b1;
              loaded_d   = loaded_q + srtf_pkg::cnt_t'(1);
              if (burst_length_i == '0) begin
                finished_d = finished_q + srtf_pkg::cnt_t'(1);
              end
              code_d = srtf_pkg::RES_LOADED;
              pid_d  = srtf_pkg::PID_BITS'(loaded_q) + srtf_pkg::PID_BITS'(1);
            end
          end else if (loaded_q == '0) begin
            code_d  = srtf_pkg::RES_IDLE;
            clock_d = clock_inc;
          end else begin
            valid_d   = 1'b0;
            clear_min = 1'b1;
            idx_d     = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one slot a cycle; the compare follows in the next cycle
        cmp_vld_d = 1'b1;
        if (last_slot) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + srtf_pkg::slot_t'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        rd_addr = pick;
        if (found) begin
          state_d = ST_UPDATE;
        end else begin
          valid_d = 1'b1;
          code_d  = srtf_pkg::RES_IDLE;
          pid_d   = '0;
          rem_d   = '0;
          tat_d   = '0;
          wt_d    = '0;
          rsp_d   = '0;
          clock_d = clock_inc;
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        // Run the pick for one tick and report it
        rd_addr      = pick;
        wr.slot      = pick;
        wr.upd_we    = 1'b1;
        wr.remaining = rem_new;
        wr.first_we  = !rd.started;
        clock_d      = clock_inc;
        valid_d      = 1'b1;
        pid_d        = srtf_pkg::PID_BITS'(pick) + srtf_pkg::PID_BITS'(1);
        if (rem_new == '0) begin
          finished_d = finished_q + srtf_pkg::cnt_t'(1);
          code_d     = srtf_pkg::RES_COMPLETED;
          rem_d      = '0;
          tat_d      = tat;
          wt_d       = tat - rd.burst;
          rsp_d      = first_run - rd.arrival;
        end else begin
          code_d = srtf_pkg::RES_RAN;
          rem_d  = rem_new;
          tat_d  = '0;
          wt_d   = '0;
          rsp_d  = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      loaded_q   <= '0;
      finished_q <= '0;
      clock_q    <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= idx_q;
      loaded_q   <= loaded_d;
      finished_q <= finished_d;
      clock_q    <= clock_d;
      valid_q    <= valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    pid_q  <= pid_d;
    rem_q  <= rem_d;
    tat_q  <= tat_d;
    wt_q   <= wt_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign result_valid_o   = valid_q;
  assign result_code_o    = code_q;
  assign process_id_o     = pid_q;
  assign time_after_o     = clock_q;
  assign remaining_left_o = rem_q;
  assign turnaround_o     = tat_q;
  assign waiting_o        = wt_q;
  assign response_o       = rsp_q;
  assign all_done_o       = (finished_q == loaded_q);

  // Checks on the sequencer and the counts
  a_fin_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q <= loaded_q)
    else $error("finished count exceeds loaded count");

  a_loaded_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= srtf_pkg::cnt_t'(srtf_pkg::MAX_PROCESSES))
    else $error("loaded count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (srtf_pkg::cnt_t'(idx_q) < loaded_q))
    else $error("scan index beyond loaded slots");

  a_update_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (result_valid_o && !busy_o))
    else $error("update did not deliver a result");

  a_accept_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !$past(valid_d))
    else $error("scan entered on a cycle that also gave a result");

endmodule

FILE: bench/shortest_remaining_time_scheduler_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the shortest-remaining-time-first scheduler core: it drives
// load and tick requests, predicts every result in-bench and compares field by field.
// Depends on srtf_pkg and shortest_remaining_time_scheduler_core.
module shortest_remaining_time_scheduler_core_test;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    srtf_pkg::code_t                code;
    logic [srtf_pkg::PID_BITS-1:0]  pid;
    srtf_pkg::time_t                time_after;
    srtf_pkg::time_t                remaining;
    srtf_pkg::time_t                turnaround;
    srtf_pkg::time_t                waiting;
    srtf_pkg::time_t                response;
    logic                           all_done;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [15:0] arrival_time_i;
  logic [15:0] burst_length_i;
  logic        result_valid_o;
  logic [2:0]  result_code_o;
  logic [4:0]  process_id_o;
  logic [15:0] time_after_o;
  logic [15:0] remaining_left_o;
  logic [15:0] turnaround_o;
  logic [15:0] waiting_o;
  logic [15:0] response_o;
  logic        all_done_o;

  // Scheduler state as the bench sees it
  srtf_pkg::time_t arrival_tbl   [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t burst_tbl     [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t remaining_tbl [srtf_pkg::MAX_PROCESSES];
  srtf_pkg::time_t first_run_tbl [srtf_pkg::MAX_PROCESSES];
  bit              started_tbl   [srtf_pkg::MAX_PROCESSES];
  int unsigned     n_loaded;
  int unsigned     n_finished;
  srtf_pkg::time_t sched_clock;

  sched_result_t pending_results[$];

  int fail_count;
  int n_loads;
  int n_full;
  int n_runs;
  int n_completed;
  int n_idle;
  int burst_left;
  bit steady_flow;
  int stall_cycles;

  shortest_remaining_time_scheduler_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .arrival_time_i   (arrival_time_i),
    .burst_length_i   (burst_length_i),
    .result_valid_o   (result_valid_o),
    .result_code_o    (result_code_o),
    .process_id_o     (process_id_o),
    .time_after_o     (time_after_o),
    .remaining_left_o (remaining_left_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o),
    .response_o       (response_o),
    .all_done_o       (all_done_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random filler for fields that a tick ignores
  function automatic srtf_pkg::time_t rand_time();
    return srtf_pkg::time_t'($urandom);
  endfunction

  // Advance the scheduler by one request and return the result it must give
  function automatic sched_result_t schedule_step(input logic kind,
                                                  input srtf_pkg::time_t arrival,
                                                  input srtf_pkg::time_t burst);
    sched_result_t   r;
    int              pick;
    int              i;
    srtf_pkg::time_t best;
    r    = '0;
    pick = -1;
    best = '0;
    r.time_after = sched_clock;
    if (kind == srtf_pkg::REQ_LOAD) begin
      if (n_loaded >= srtf_pkg::MAX_PROCESSES) begin
        r.code = srtf_pkg::RES_FULL;
      end else begin
        arrival_tbl[n_loaded]   = arrival;
        burst_tbl[n_loaded]     = burst;
        remaining_tbl[n_loaded] = burst;
        first_run_tbl[n_loaded] = '0;
        started_tbl[n_loaded]   = 1'b0;
        // a zero burst is stored as already finished
        if (burst == '0) n_finished++;
        n_loaded++;
        r.code = srtf_pkg::RES_LOADED;
        r.pid  = srtf_pkg::PID_BITS'(n_loaded);
      end
    end else begin
      // pick the arrived, unfinished process with least remaining time, lowest slot on ties
      for (i = 0; i < n_loaded; i++) begin
        if (arrival_tbl[i] <= sched_clock && remaining_tbl[i] != '0 &&
            (pick < 0 || remaining_tbl[i] < best)) begin
          pick = i;
          best = remaining_tbl[i];
        end
      end
      if (pick < 0) begin
        sched_clock  = sched_clock + 1'b1;
        r.code       = srtf_pkg::RES_IDLE;
        r.time_after = sched_clock;
      end else begin
        if (!started_tbl[pick]) begin
          started_tbl[pick]   = 1'b1;
          first_run_tbl[pick] = sched_clock;
        end
        remaining_tbl[pick] = remaining_tbl[pick] - 1'b1;
        sched_clock         = sched_clock + 1'b1;
        r.pid               = srtf_pkg::PID_BITS'(pick + 1);
        r.time_after        = sched_clock;
        if (remaining_tbl[pick] == '0) begin
          n_finished++;
          r.code       = srtf_pkg::RES_COMPLETED;
          r.turnaround = sched_clock - arrival_tbl[pick];
          r.waiting    = r.turnaround - burst_tbl[pick];
          r.response   = first_run_tbl[pick] - arrival_tbl[pick];
        end else begin
          r.code      = srtf_pkg::RES_RAN;
          r.remaining = remaining_tbl[pick];
        end
      end
    end
    r.all_done = (n_finished == n_loaded);
    return r;
  endfunction

  // Send one request; entered and left at a falling edge
  task automatic send_request(input logic kind, input srtf_pkg::time_t arrival,
                              input srtf_pkg::time_t burst);
    int gap;
    gap = 0;
    if (!steady_flow) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 30))
                                                 : int'($urandom_range(1, 6));
        burst_left = int'($urandom_range(1, 24));
      end
      burst_left--;
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    req_type_i     <= kind;
    arrival_time_i <= arrival;
    burst_length_i <= burst;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(schedule_step(kind, arrival, burst));
    @(negedge clk_i);
  endtask

  // Hold off requests until every expected result has come
  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    sched_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, code %0d process %0d", $time, result_code_o,
               process_id_o);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("result_code", 16'(want.code), 16'(result_code_o));
      compare_field("process_id", 16'(want.pid), 16'(process_id_o));
      compare_field("time_after", want.time_after, time_after_o);
      compare_field("remaining_left", want.remaining, remaining_left_o);
      compare_field("turnaround", want.turnaround, turnaround_o);
      compare_field("waiting", want.waiting, waiting_o);
      compare_field("response", want.response, response_o);
      compare_field("all_done", 16'(want.all_done), 16'(all_done_o));
      case (want.code)
        srtf_pkg::RES_RAN:       n_runs++;
        srtf_pkg::RES_COMPLETED: n_completed++;
        srtf_pkg::RES_IDLE:      n_idle++;
        srtf_pkg::RES_LOADED:    n_loads++;
        default:                 n_full++;
      endcase
    end
  endtask

  // Check each result as it is strobed
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) check_result();
  end

  // End the run if nothing moves for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i === 1'b1 && busy_o === 1'b0) || result_valid_o === 1'b1)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: no request taken and no result for %0d cycles", $time, STALL_LIMIT);
    $display("shortest_remaining_time_scheduler_core_test NOT OK");
    $finish;
  end

  // Tick with nothing loaded: idle, everything counts as done
  task automatic test_idle_ticks();
    repeat (3) send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
    wait_for_results();
  endtask

  // Zero burst, a late-run process, a tie and a preempting arrival
  task automatic test_scheduling();
    send_request(srtf_pkg::REQ_LOAD, sched_clock, '0);
    send_request(srtf_pkg::REQ_LOAD, '0, 16'd1);
    send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
    send_request(srtf_pkg::REQ_LOAD, sched_clock, 16'd3);
    send_request(srtf_pkg::REQ_LOAD, sched_clock, 16'd3);
    send_request(srtf_pkg::REQ_LOAD, sched_clock + 16'd1, 16'd1);
    repeat (10) send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
    wait_for_results();
  endtask

  // Mostly ticks, with processes loaded now and then; leave two slots spare
  task automatic test_random_mix();
    int              n;
    int              load_odds;
    int              arrival;
    srtf_pkg::time_t burst;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      load_odds = (n_finished == n_loaded) ? 10 : 150;
      if (n_loaded < srtf_pkg::MAX_PROCESSES - 2 && $urandom_range(1, load_odds) == 1) begin
        case ($urandom_range(0, 9))
          0:       burst = '0;
          1, 2:    burst = srtf_pkg::time_t'($urandom_range(1, 4));
          default: burst = srtf_pkg::time_t'($urandom_range(5, 300));
        endcase
        arrival = int'(sched_clock) + int'($urandom_range(0, 40)) - 15;
        if (arrival < 0) arrival = 0;
        send_request(srtf_pkg::REQ_LOAD, srtf_pkg::time_t'(arrival), burst);
      end else begin
        send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
      end
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Fill up to the last slot, load the longest burst and run it for a while
  task automatic test_long_burst();
    while (n_loaded < srtf_pkg::MAX_PROCESSES - 1)
      send_request(srtf_pkg::REQ_LOAD, sched_clock, srtf_pkg::time_t'($urandom_range(1, 3)));
    send_request(srtf_pkg::REQ_LOAD, '0, '1);
    while (remaining_tbl[srtf_pkg::MAX_PROCESSES-1] > 16'hFFF0)
      send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
    wait_for_results();
  endtask

  // Loads into a full table are refused
  task automatic test_table_full();
    send_request(srtf_pkg::REQ_LOAD, '1, '1);
    send_request(srtf_pkg::REQ_LOAD, '0, '0);
    send_request(srtf_pkg::REQ_LOAD, rand_time(), rand_time());
    repeat (3) send_request(srtf_pkg::REQ_TICK, rand_time(), rand_time());
    wait_for_results();
  endtask

  initial begin
    start_i        = 1'b0;
    req_type_i     = srtf_pkg::REQ_LOAD;
    arrival_time_i = '0;
    burst_length_i = '0;
    rst_ni         = 1'b0;
    for (int i = 0; i < srtf_pkg::MAX_PROCESSES; i++) begin
      arrival_tbl[i]   = '0;
      burst_tbl[i]     = '0;
      remaining_tbl[i] = '0;
      first_run_tbl[i] = '0;
      started_tbl[i]   = 1'b0;
    end
    n_loaded    = 0;
    n_finished  = 0;
    sched_clock = '0;
    fail_count  = 0;
    n_loads     = 0;
    n_full      = 0;
    n_runs      = 0;
    n_completed = 0;
    n_idle      = 0;
    burst_left  = 0;
    steady_flow = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_ticks();
    test_scheduling();
    test_random_mix();
    test_long_burst();
    test_table_full();

    // let any stray result show up
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d loads, %0d refused loads, %0d runs, %0d completions, %0d idle ticks",
             n_loads, n_full, n_runs, n_completed, n_idle);
    $display("Covered ties, preemption, late arrivals, zero and maximum bursts, a full table");
    if (fail_count == 0) begin
      $display("shortest_remaining_time_scheduler_core_test OK");
    end else begin
      $display("shortest_remaining_time_scheduler_core_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/srtf_pkg.sv
sv/srtf_table.sv
sv/srtf_min_unit.sv
sv/shortest_remaining_time_scheduler_core.sv
bench/shortest_remaining_time_scheduler_core_test.sv
